### rtl/lz77d_pkg.sv
// ---------------------------------------------------------------------------
// lz77d_pkg - shared types and constants of the token-stream decompressor
// codes for input modes, result status and parser phases, plus the job record
// ---------------------------------------------------------------------------
package lz77d_pkg;

    // input item modes
    localparam logic [1:0] MODE_BYTE  = 2'd0;
    localparam logic [1:0] MODE_DRAIN = 2'd1;
    localparam logic [1:0] MODE_END   = 2'd2;

    // result status codes
    localparam logic [1:0] ST_RUN     = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_CORRUPT = 2'd2;
    localparam logic [1:0] ST_REFUSED = 2'd3;

    // parser phases
    localparam logic [2:0] PH_TOK_LO  = 3'd0;
    localparam logic [2:0] PH_TOK_HI  = 3'd1;
    localparam logic [2:0] PH_LIT_VAR = 3'd2;
    localparam logic [2:0] PH_MAT_VAR = 3'd3;
    localparam logic [2:0] PH_LITS    = 3'd4;
    localparam logic [2:0] PH_COPY    = 3'd5;
    localparam logic [2:0] PH_DONE    = 3'd6;

    localparam int WINDOW_DEPTH_DEF = 4096;
    // low bits of the output position carried per job, enough for the largest window
    localparam int POS_W       = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int EXP_W       = 32;
    localparam int CNT_W       = 33;
    localparam int OFF_W       = 12;

    typedef struct packed {
        logic             emit;
        logic             is_copy;
        logic [7:0]       lit_byte;
        logic [POS_W-1:0] wpos;
        logic [POS_W-1:0] rpos;
        logic             copy_pending;
        logic [1:0]       status;
    } t_job;

endpackage

### rtl/lz77d_ifs.sv
// ---------------------------------------------------------------------------
// lz77d channel interfaces
// valid/ready channels for compressed input items and decompressed results
// ---------------------------------------------------------------------------
interface lz77d_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] in_byte;

    modport source (output valid, output mode, output in_byte, input ready);
    modport sink   (input valid, input mode, input in_byte, output ready);
endinterface

interface lz77d_out_if;
    logic       valid;
    logic       ready;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       copy_pending;
    logic [1:0] status;

    modport source (output valid, output out_valid, output out_byte,
                    output copy_pending, output status, input ready);
    modport sink   (input valid, input out_valid, input out_byte,
                    input copy_pending, input status, output ready);
endinterface

### rtl/lz77_token_stream_decompressor_core.sv
// ---------------------------------------------------------------------------
// lz77_token_stream_decompressor_core - token-stream lz77 decoder
// path: a job passes the queue and then the result register once its input is
//   taken; throughput: one input transaction and one result per cycle while the
//   queue has room and results are taken, set by the parser state loop and the
//   single history write port
// reset: synchronous active low; clears parser, counts, queue and result
//   register; the history window is not cleared and needs no clearing pass
// ---------------------------------------------------------------------------
module lz77_token_stream_decompressor_core #(
    parameter int WINDOW_DEPTH = lz77d_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lz77d_pkg::EXP_W-1:0] i_cfg_wdata,
    lz77d_in_if.sink                    i_item,
    lz77d_out_if.source                 o_result
);
    // parser to queue
    logic            push;
    lz77d_pkg::t_job push_job;
    logic            q_full;

    // queue to output side
    logic            pop;
    logic            head_valid;
    lz77d_pkg::t_job head;

    // front: classifies each transaction and keeps all token state
    lz77d_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (i_item),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_job       (push_job)
    );

    // short job queue decouples the two sides
    lz77d_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (push_job),
        .o_full       (q_full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    // back: history reads, window writes and the result register
    lz77d_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_result     (o_result)
    );

    // a corrupt stream never delivers a byte or a pending copy
    a_corrupt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.status == lz77d_pkg::ST_CORRUPT)
        |-> (!o_result.out_valid && !o_result.copy_pending))
        else $error("corrupt result carries data");

    // corrupt status is sticky on back-to-back results
    a_corrupt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.ready && o_result.status == lz77d_pkg::ST_CORRUPT)
        |=> (!(o_result.valid && o_result.ready)
             || o_result.status == lz77d_pkg::ST_CORRUPT))
        else $error("corrupt status lost");

    // finished status is sticky on back-to-back results
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.ready && o_result.status == lz77d_pkg::ST_DONE)
        |=> (!(o_result.valid && o_result.ready)
             || o_result.status == lz77d_pkg::ST_DONE))
        else $error("finished status lost");

    // no byte comes out without a valid flag
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.out_valid) |-> (o_result.out_byte == 8'd0))
        else $error("stray output byte");
endmodule

### rtl/lz77d_ram.sv
// ---------------------------------------------------------------------------
// lz77d_ram - generic single-write, single-read memory
// one write port, one read port with registered read data and read enable
// ---------------------------------------------------------------------------
module lz77d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/lz77d_front.sv
// ---------------------------------------------------------------------------
// lz77d_front - token parser
// takes one input transaction per cycle while the queue has room, tracks token
// state and counts, and turns each into a job for the history/output side
// ---------------------------------------------------------------------------
module lz77d_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [lz77d_pkg::EXP_W-1:0]  i_cfg_wdata,
    lz77d_in_if.sink                     i_item,
    input  logic                         i_q_full,
    output logic                         o_push,
    output lz77d_pkg::t_job              o_job
);
    localparam int CW = lz77d_pkg::CNT_W;
    localparam int OW = lz77d_pkg::OFF_W;

    typedef struct packed {
        logic          err;
        logic [2:0]    phase;
        logic [CW-1:0] match;
    } t_fin;

    logic [2:0]    r_phase,    n_phase;
    logic [7:0]    r_tok_lo,   n_tok_lo;
    logic [1:0]    r_ext,      n_ext;
    logic [31:0]   r_acc,      n_acc;
    logic [2:0]    r_shift,    n_shift;
    logic [CW-1:0] r_lit,      n_lit;
    logic [CW-1:0] r_match,    n_match;
    logic [OW-1:0] r_off,      n_off;
    logic [CW-1:0] r_prod,     n_prod;
    logic [OW-1:0] r_psmall,   n_psmall;
    logic [CW-1:0] r_room,     n_room;
    logic [lz77d_pkg::EXP_W-1:0] r_expected, n_expected;
    logic          r_err,      n_err;

    logic          accept;
    logic [7:0]    b;
    logic [4:0]    sh;
    logic [31:0]   part;
    logic [31:0]   acc_f;
    logic [2:0]    shift_inc;
    logic [15:0]   tv;
    logic [CW-1:0] lit_tmp;
    logic [CW-1:0] mat_tmp;
    logic          emit;
    t_fin          fin;

    // token checks made once all its counts are known
    function automatic t_fin finish(input logic [CW-1:0] lit, input logic [CW-1:0] mat,
                                    input logic [OW-1:0] off, input logic [CW-1:0] room,
                                    input logic [OW-1:0] psmall);
        t_fin          f;
        logic [OW:0]   reach;
        logic          off_bad;
        logic          mat_bad;
        reach   = {1'b0, psmall} + {1'b0, lit[OW-1:0]};
        off_bad = (lit[CW-1:OW] == '0) && ({1'b0, off} > reach);
        mat_bad = mat > (room - lit);
        f.match = (off != '0) ? mat : '0;
        f.err   = (lit > room) || ((off != '0) && (off_bad || mat_bad));
        if (lit != '0) begin
            f.phase = lz77d_pkg::PH_LITS;
        end else if (f.match != '0) begin
            f.phase = lz77d_pkg::PH_COPY;
        end else begin
            f.phase = lz77d_pkg::PH_TOK_LO;
        end
        return f;
    endfunction

    assign accept       = i_item.valid && i_item.ready;
    assign i_item.ready = !i_q_full;
    assign o_push       = accept;
    assign b            = i_item.in_byte;

    // varint group placement, bits past 31 fall off
    assign sh        = 5'(r_shift) * 5'd7;
    assign part      = {25'd0, b[6:0]} << sh;
    assign acc_f     = r_acc | part;
    assign shift_inc = r_shift + 3'd1;
    assign tv        = {b, r_tok_lo};

    always_comb begin
        n_phase    = r_phase;
        n_tok_lo   = r_tok_lo;
        n_ext      = r_ext;
        n_acc      = r_acc;
        n_shift    = r_shift;
        n_lit      = r_lit;
        n_match    = r_match;
        n_off      = r_off;
        n_prod     = r_prod;
        n_psmall   = r_psmall;
        n_room     = r_room;
        n_expected = r_expected;
        n_err      = r_err;
        emit       = 1'b0;
        lit_tmp    = '0;
        mat_tmp    = '0;
        fin        = '0;

        o_job              = '0;
        o_job.wpos         = r_prod[lz77d_pkg::POS_W-1:0];
        o_job.rpos         = r_prod[lz77d_pkg::POS_W-1:0] - lz77d_pkg::POS_W'(r_off);
        o_job.status       = lz77d_pkg::ST_RUN;

        if (accept && !r_err && r_phase != lz77d_pkg::PH_DONE) begin
            unique case (i_item.mode)
                lz77d_pkg::MODE_END: begin
                    if (r_phase == lz77d_pkg::PH_TOK_LO && r_prod == CW'(r_expected)) begin
                        n_phase = lz77d_pkg::PH_DONE;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                lz77d_pkg::MODE_DRAIN: begin
                    if (r_phase == lz77d_pkg::PH_COPY) begin
                        emit          = 1'b1;
                        o_job.is_copy = 1'b1;
                        n_match       = r_match - CW'(1);
                        if (r_match == CW'(1)) begin
                            n_phase = lz77d_pkg::PH_TOK_LO;
                        end
                    end
                end
                lz77d_pkg::MODE_BYTE: begin
                    unique case (r_phase)
                        lz77d_pkg::PH_TOK_LO: begin
                            if (r_room != '0) begin
                                n_tok_lo = b;
                                n_phase  = lz77d_pkg::PH_TOK_HI;
                            end
                        end
                        lz77d_pkg::PH_TOK_HI: begin
                            n_ext   = {tv[1:0] == 2'b11, tv[15:14] == 2'b11};
                            n_off   = tv[13:2];
                            lit_tmp = n_ext[0] ? '0 : CW'(tv[15:14]);
                            mat_tmp = n_ext[1] ? '0 : CW'(tv[1:0]) + CW'(3);
                            n_lit   = lit_tmp;
                            n_match = mat_tmp;
                            n_acc   = '0;
                            n_shift = '0;
                            if (n_ext[0]) begin
                                n_phase = lz77d_pkg::PH_LIT_VAR;
                            end else if (n_ext[1]) begin
                                n_phase = lz77d_pkg::PH_MAT_VAR;
                            end else begin
                                fin     = finish(lit_tmp, mat_tmp, tv[13:2], r_room, r_psmall);
                                n_err   = fin.err;
                                n_match = fin.match;
                                n_phase = fin.phase;
                            end
                        end
                        lz77d_pkg::PH_LIT_VAR, lz77d_pkg::PH_MAT_VAR: begin
                            if (!b[7]) begin
                                n_acc   = '0;
                                n_shift = '0;
                                if (r_phase == lz77d_pkg::PH_LIT_VAR) begin
                                    lit_tmp = CW'(acc_f) + CW'(3);
                                    n_lit   = lit_tmp;
                                    if (r_ext[1]) begin
                                        n_phase = lz77d_pkg::PH_MAT_VAR;
                                    end else begin
                                        fin     = finish(lit_tmp, r_match, r_off, r_room,
                                                         r_psmall);
                                        n_err   = fin.err;
                                        n_match = fin.match;
                                        n_phase = fin.phase;
                                    end
                                end else begin
                                    mat_tmp = CW'(acc_f) + CW'(6);
                                    fin     = finish(r_lit, mat_tmp, r_off, r_room, r_psmall);
                                    n_err   = fin.err;
                                    n_match = fin.match;
                                    n_phase = fin.phase;
                                end
                            end else begin
                                n_acc   = acc_f;
                                n_shift = shift_inc;
                                if (shift_inc >= 3'd5) begin
                                    n_err = 1'b1;
                                end
                            end
                        end
                        lz77d_pkg::PH_LITS: begin
                            emit           = 1'b1;
                            o_job.lit_byte = b;
                            n_lit          = r_lit - CW'(1);
                            if (r_lit == CW'(1)) begin
                                n_phase = (r_match != '0) ? lz77d_pkg::PH_COPY
                                                          : lz77d_pkg::PH_TOK_LO;
                            end
                        end
                        lz77d_pkg::PH_COPY: begin
                            o_job.status = lz77d_pkg::ST_REFUSED;
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end

        if (emit) begin
            n_prod   = r_prod + CW'(1);
            n_psmall = (r_psmall != '1) ? r_psmall + OW'(1) : r_psmall;
            n_room   = (r_room != '0) ? r_room - CW'(1) : r_room;
        end

        // corrupt stream drops every pending byte
        if (n_err) begin
            n_lit   = '0;
            n_match = '0;
        end

        if (n_err) begin
            o_job.status   = lz77d_pkg::ST_CORRUPT;
            o_job.emit     = 1'b0;
            o_job.is_copy  = 1'b0;
            o_job.lit_byte = '0;
        end else begin
            o_job.emit = emit;
            if (n_phase == lz77d_pkg::PH_DONE) begin
                o_job.status = lz77d_pkg::ST_DONE;
            end
        end
        o_job.copy_pending = !n_err && (n_phase == lz77d_pkg::PH_COPY);

        if (i_cfg_we) begin
            n_expected = i_cfg_wdata;
            n_room     = (CW'(i_cfg_wdata) > r_prod) ? CW'(i_cfg_wdata) - r_prod : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= lz77d_pkg::PH_TOK_LO;
            r_tok_lo   <= '0;
            r_ext      <= '0;
            r_acc      <= '0;
            r_shift    <= '0;
            r_lit      <= '0;
            r_match    <= '0;
            r_off      <= '0;
            r_prod     <= '0;
            r_psmall   <= '0;
            r_room     <= '0;
            r_expected <= '0;
            r_err      <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_tok_lo   <= n_tok_lo;
            r_ext      <= n_ext;
            r_acc      <= n_acc;
            r_shift    <= n_shift;
            r_lit      <= n_lit;
            r_match    <= n_match;
            r_off      <= n_off;
            r_prod     <= n_prod;
            r_psmall   <= n_psmall;
            r_room     <= n_room;
            r_expected <= n_expected;
            r_err      <= n_err;
        end
    end
endmodule

### rtl/lz77d_queue.sv
// ---------------------------------------------------------------------------
// lz77d_queue - job queue between parser and output side
// small fifo so either side can stall without holding the other until full
// ---------------------------------------------------------------------------
module lz77d_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lz77d_pkg::t_job i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_head_valid,
    output lz77d_pkg::t_job o_head
);
    localparam int QD = lz77d_pkg::QUEUE_DEPTH;
    localparam int PW = (QD > 1) ? $clog2(QD) : 1;
    localparam int CW = $clog2(QD + 1);

    lz77d_pkg::t_job r_slot [QD];
    logic [PW-1:0]   r_wptr, n_wptr;
    logic [PW-1:0]   r_rptr, n_rptr;
    logic [CW-1:0]   r_count, n_count;
    logic            do_pop;

    assign o_full       = (r_count == CW'(QD));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_slot[r_rptr];
    assign do_pop       = i_pop && o_head_valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(QD - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PW'(QD - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (i_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && do_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end
endmodule

### rtl/lz77d_back.sv
// ---------------------------------------------------------------------------
// lz77d_back - history window and result register
// reads match bytes from the window, writes every delivered byte back, and
// holds the result transaction until it is taken
// ---------------------------------------------------------------------------
module lz77d_back #(
    parameter int WINDOW_DEPTH = lz77d_pkg::WINDOW_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_head_valid,
    input  lz77d_pkg::t_job i_head,
    output logic            o_pop,
    lz77d_out_if.source     o_result
);
    localparam int AW = $clog2(WINDOW_DEPTH);

    logic            r_b_valid;
    lz77d_pkg::t_job r_job;
    logic            r_fwd;
    logic [7:0]      r_fwd_byte;

    logic            advance;
    logic            rd_en;
    logic [AW-1:0]   raddr;
    logic [7:0]      rdata;
    logic            wr_en;
    logic [AW-1:0]   waddr;
    logic [7:0]      out_byte;
    logic            fwd_hit;

    assign advance = !r_b_valid || o_result.ready;
    assign o_pop   = advance && i_head_valid;
    assign rd_en   = o_pop && i_head.is_copy;
    assign raddr   = i_head.rpos[AW-1:0];
    assign waddr   = r_job.wpos[AW-1:0];

    assign out_byte = r_job.is_copy ? (r_fwd ? r_fwd_byte : rdata) : r_job.lit_byte;
    // window is written when the byte leaves, in stream order
    assign wr_en    = r_b_valid && o_result.ready && r_job.emit;
    // read of the byte being written in the same cycle
    assign fwd_hit  = wr_en && (waddr == raddr);

    lz77d_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (waddr),
        .i_wdata (out_byte),
        .i_re    (rd_en),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_job      <= i_head;
            r_fwd      <= fwd_hit;
            r_fwd_byte <= out_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (advance) begin
            r_b_valid <= i_head_valid;
        end
    end

    assign o_result.valid        = r_b_valid;
    assign o_result.out_valid    = r_job.emit;
    assign o_result.out_byte     = out_byte;
    assign o_result.copy_pending = r_job.copy_pending;
    assign o_result.status       = r_job.status;
endmodule
